// ===== hdl/affine_gap_alignment_rescore_defines.svh =====
// Assertion macros shared by the affine gap rescoring modules.
`ifndef AFFINE_GAP_ALIGNMENT_RESCORE_DEFINES_SVH
`define AFFINE_GAP_ALIGNMENT_RESCORE_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define AGAR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Assertion failed.");

// The consequent holds in the cycle after the antecedent.
`define AGAR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Assertion failed.");

`endif

// ===== hdl/agar_pkg.sv =====
// Shared types, constants and the residue lookup of the affine gap rescorer.
package agar_pkg;

    localparam int ALPHABET_LEN = 24;
    localparam logic [8*ALPHABET_LEN-1:0] ALPHABET_STR = "ARNDCQEGHILKMFPSTWYVBZX*";
    localparam logic [7:0] GAP_CHAR = 8'h2D;

    localparam int CHAR_W = 8;
    localparam int IDX_W = 5;
    localparam int SCORE_W = 32;
    localparam int VALUE_W = 8;
    localparam int PEN_W = 8;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W = 8;
    localparam int FIFO_DEPTH = 4;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_PAIR = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_GAP_OPEN = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAP_EXTEND = 1'b1;

    localparam logic [PEN_W-1:0] GAP_OPEN_RESET = 8'd11;
    localparam logic [PEN_W-1:0] GAP_EXTEND_RESET = 8'd1;

    typedef enum logic [2:0] {
        KIND_SKIP  = 3'd0,
        KIND_WRITE = 3'd1,
        KIND_QGAP  = 3'd2,
        KIND_SGAP  = 3'd3,
        KIND_PAIR  = 3'd4
    } item_kind_t;

    typedef enum logic [1:0] {
        SIDE_NONE    = 2'b00,
        SIDE_QUERY   = 2'b01,
        SIDE_SUBJECT = 2'b10
    } gap_side_t;

    typedef struct packed {
        item_kind_t               kind;
        logic                     last;
        logic signed [VALUE_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } residue_t;

    function automatic residue_t residue_lookup(input logic [CHAR_W-1:0] c);
        residue_t r;
        r = '0;
        for (int i = ALPHABET_LEN - 1; i >= 0; i--)
        begin
            if (ALPHABET_STR[CHAR_W*(ALPHABET_LEN-1-i) +: CHAR_W] == c)
            begin
                r.found = 1'b1;
                r.idx = IDX_W'(i);
            end
        end
        return r;
    endfunction

endpackage

// ===== hdl/agar_front.sv =====
// Front part: takes input words, classifies them and forms table addresses.
module agar_front
    import agar_pkg::*;
#(
    parameter int ALPHABET_SIZE = 24,
    parameter int ADDR_W = 10
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      command,
    input  logic [CHAR_W-1:0]         query_char,
    input  logic [CHAR_W-1:0]         subject_char,
    input  logic [IDX_W-1:0]          table_row,
    input  logic [IDX_W-1:0]          table_col,
    input  logic signed [VALUE_W-1:0] table_value,
    input  logic                      last_pair,
    input  logic                      fifo_full,
    output logic                      push,
    output entry_t                    entry,
    output logic [ADDR_W-1:0]         addr
);

    localparam logic [IDX_W:0] SIZE_LIMIT = (IDX_W + 1)'(ALPHABET_SIZE);

    logic              front_valid_reg;
    logic              front_valid_next;
    entry_t            entry_reg;
    entry_t            entry_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;
    logic              accept;
    residue_t          res_q;
    residue_t          res_s;
    logic              known_q;
    logic              known_s;
    logic [IDX_W-1:0]  sel_row;
    logic [IDX_W-1:0]  sel_col;

    assign in_stall = front_valid_reg && fifo_full;
    assign accept = in_valid && !in_stall;
    assign push = front_valid_reg && !fifo_full;
    assign entry = entry_reg;
    assign addr = addr_reg;

    always_comb
    begin
        res_q = residue_lookup(query_char);
        res_s = residue_lookup(subject_char);
        known_q = res_q.found && ({1'b0, res_q.idx} < SIZE_LIMIT);
        known_s = res_s.found && ({1'b0, res_s.idx} < SIZE_LIMIT);
        entry_next.value = table_value;
        entry_next.last = 1'b0;
        entry_next.kind = KIND_SKIP;
        sel_row = res_q.idx;
        sel_col = res_s.idx;
        if (command == CMD_WRITE)
        begin
            sel_row = table_row;
            sel_col = table_col;
            if (({1'b0, table_row} < SIZE_LIMIT) && ({1'b0, table_col} < SIZE_LIMIT))
            begin
                entry_next.kind = KIND_WRITE;
            end
        end
        else
        begin
            entry_next.last = last_pair;
            if (query_char == GAP_CHAR)
            begin
                entry_next.kind = KIND_QGAP;
            end
            else if (subject_char == GAP_CHAR)
            begin
                entry_next.kind = KIND_SGAP;
            end
            else if (known_q && known_s)
            begin
                entry_next.kind = KIND_PAIR;
            end
        end
        addr_next = ADDR_W'(ADDR_W'(sel_row) * ADDR_W'(ALPHABET_SIZE) + ADDR_W'(sel_col));
        front_valid_next = accept || (front_valid_reg && fifo_full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg <= entry_next;
            addr_reg <= addr_next;
        end
    end

endmodule

// ===== hdl/agar_fifo.sv =====
// Short queue of classified words between the front and back parts.
`include "affine_gap_alignment_rescore_defines.svh"

module agar_fifo
    import agar_pkg::*;
#(
    parameter int WIDTH = 22
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [WIDTH-1:0] mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full = (count_reg == CNT_W'(FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    `AGAR_ASSERT_IMPL(a_no_push_full, push, !full)
    `AGAR_ASSERT_IMPL(a_no_pop_empty, pop, !empty)
    `AGAR_ASSERT_NEXT(a_fills_up, push && !pop && count_reg == CNT_W'(FIFO_DEPTH - 1), full)

endmodule

// ===== hdl/agar_back.sv =====
// Back part: substitution table, score accumulator, gap state and result register.
`include "affine_gap_alignment_rescore_defines.svh"

module agar_back
    import agar_pkg::*;
#(
    parameter int ALPHABET_SIZE = 24,
    parameter int ADDR_W = 10
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fifo_empty,
    input  entry_t                       head_entry,
    input  logic [ADDR_W-1:0]            head_addr,
    output logic                         pop,
    input  logic                         cfg_we,
    input  logic [CFG_INDEX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [SCORE_W-1:0]    total_score
);

    localparam int TABLE_DEPTH = ALPHABET_SIZE * ALPHABET_SIZE;
    localparam int SUM_W = SCORE_W + 2;
    localparam int DELTA_W = PEN_W + 2;
    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(-64'sd2147483648);

    logic signed [VALUE_W-1:0] table_mem [TABLE_DEPTH];

    logic [PEN_W-1:0]          gap_open_reg;
    logic [PEN_W-1:0]          gap_extend_reg;
    logic                      s1_valid_reg;
    logic                      s1_valid_next;
    item_kind_t                s1_kind_reg;
    logic                      s1_last_reg;
    logic signed [VALUE_W-1:0] rd_reg;
    logic signed [SCORE_W-1:0] acc_reg;
    logic signed [SCORE_W-1:0] acc_next;
    gap_side_t                 gap_side_reg;
    gap_side_t                 gap_side_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic signed [SCORE_W-1:0] total_score_reg;
    logic signed [SCORE_W-1:0] total_score_next;
    logic                      advance;
    logic [DELTA_W-1:0]        pen_sum;
    logic signed [DELTA_W-1:0] delta;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SCORE_W-1:0] sat;
    logic                      touch;
    gap_side_t                 target_side;

    assign advance = !out_valid_reg || !out_stall;
    assign pop = advance && !fifo_empty;
    assign out_valid = out_valid_reg;
    assign total_score = total_score_reg;

    always_comb
    begin
        target_side = (s1_kind_reg == KIND_QGAP) ? SIDE_QUERY : SIDE_SUBJECT;
        pen_sum = DELTA_W'(gap_extend_reg);
        if (gap_side_reg != target_side)
        begin
            pen_sum = DELTA_W'(pen_sum + DELTA_W'(gap_open_reg));
        end
        delta = '0;
        touch = 1'b0;
        gap_side_next = gap_side_reg;
        case (s1_kind_reg)
            KIND_QGAP, KIND_SGAP:
            begin
                delta = DELTA_W'(0) - $signed(pen_sum);
                touch = 1'b1;
                gap_side_next = target_side;
            end
            KIND_PAIR:
            begin
                delta = DELTA_W'(rd_reg);
                touch = 1'b1;
                gap_side_next = SIDE_NONE;
            end
            default:
            begin
                delta = '0;
            end
        endcase
        sum = SUM_W'(acc_reg) + SUM_W'(delta);
        if (sum > SAT_MAX)
        begin
            sat = SCORE_W'(SAT_MAX);
        end
        else if (sum < SAT_MIN)
        begin
            sat = SCORE_W'(SAT_MIN);
        end
        else
        begin
            sat = SCORE_W'(sum);
        end
        acc_next = acc_reg;
        out_valid_next = out_valid_reg;
        total_score_next = total_score_reg;
        s1_valid_next = s1_valid_reg;
        if (advance)
        begin
            s1_valid_next = pop;
            out_valid_next = s1_valid_reg && s1_last_reg;
            if (s1_valid_reg)
            begin
                if (touch)
                begin
                    acc_next = sat;
                end
                else
                begin
                    gap_side_next = gap_side_reg;
                end
                total_score_next = touch ? sat : acc_reg;
                if (s1_last_reg)
                begin
                    acc_next = '0;
                    gap_side_next = SIDE_NONE;
                end
            end
            else
            begin
                gap_side_next = gap_side_reg;
            end
        end
        else
        begin
            gap_side_next = gap_side_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_open_reg <= GAP_OPEN_RESET;
            gap_extend_reg <= GAP_EXTEND_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GAP_OPEN:   gap_open_reg <= cfg_data;
                REG_GAP_EXTEND: gap_extend_reg <= cfg_data;
                default:        gap_open_reg <= gap_open_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            acc_reg <= '0;
            gap_side_reg <= SIDE_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            acc_reg <= acc_next;
            gap_side_reg <= gap_side_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_score_reg <= total_score_next;
        if (pop)
        begin
            s1_kind_reg <= head_entry.kind;
            s1_last_reg <= head_entry.last;
            if (head_entry.kind == KIND_WRITE)
            begin
                table_mem[head_addr] <= head_entry.value;
            end
            else
            begin
                rd_reg <= table_mem[head_addr];
            end
        end
    end

    `AGAR_ASSERT_NEXT(a_clear_after_last, advance && s1_valid_reg && s1_last_reg, out_valid_reg && acc_reg == '0 && gap_side_reg == SIDE_NONE)
    `AGAR_ASSERT_NEXT(a_hold_on_stall, out_valid_reg && out_stall, out_valid_reg && $stable(s1_valid_reg) && $stable(acc_reg))
    `AGAR_ASSERT_IMPL(a_drop_only_taken, $fell(out_valid_reg), !$past(out_stall))

endmodule

// ===== hdl/affine_gap_alignment_rescore.sv =====
// Top level of the affine gap alignment rescorer: front, queue and back parts.
//
// Channel  Dir  Handshake                Fields
// in       in   in_valid / in_stall      command, query_char, subject_char, table_row,
//                                        table_col, table_value, last_pair
// out      out  out_valid / out_stall    total_score
// cfg      in   cfg_we (no wait)         cfg_index, cfg_data
//
// One input word is taken every cycle while in_stall is low, since the table does one write
// or one read per word. The result word of a last pair passes through the front register,
// the queue, the table read and the accumulate step in that order.
// Reset loads gap open 11 and gap extend 1 and clears score and gap state, not the table.
// out_stall freezes the back part while out_valid is high, and the four-word queue keeps
// the front running; in_stall rises once the front register and the queue are full.
module affine_gap_alignment_rescore
    import agar_pkg::*;
#(
    parameter int ALPHABET_SIZE = 24
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         command,
    input  logic [CHAR_W-1:0]            query_char,
    input  logic [CHAR_W-1:0]            subject_char,
    input  logic [IDX_W-1:0]             table_row,
    input  logic [IDX_W-1:0]             table_col,
    input  logic signed [VALUE_W-1:0]    table_value,
    input  logic                         last_pair,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [SCORE_W-1:0]    total_score,
    input  logic                         cfg_we,
    input  logic [CFG_INDEX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    localparam int ADDR_W = $clog2(ALPHABET_SIZE * ALPHABET_SIZE);
    localparam int Q_W = $bits(entry_t) + ADDR_W;

    logic              push;
    logic              pop;
    logic              fifo_full;
    logic              fifo_empty;
    entry_t            front_entry;
    logic [ADDR_W-1:0] front_addr;
    logic [Q_W-1:0]    head_data;
    entry_t            head_entry;
    logic [ADDR_W-1:0] head_addr;

    assign head_entry = entry_t'(head_data[Q_W-1:ADDR_W]);
    assign head_addr = head_data[ADDR_W-1:0];

    agar_front #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .ADDR_W        (ADDR_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .query_char   (query_char),
        .subject_char (subject_char),
        .table_row    (table_row),
        .table_col    (table_col),
        .table_value  (table_value),
        .last_pair    (last_pair),
        .fifo_full    (fifo_full),
        .push         (push),
        .entry        (front_entry),
        .addr         (front_addr)
    );

    agar_fifo #(
        .WIDTH (Q_W)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data ({front_entry, front_addr}),
        .pop     (pop),
        .rd_data (head_data),
        .full    (fifo_full),
        .empty   (fifo_empty)
    );

    agar_back #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .ADDR_W        (ADDR_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .fifo_empty  (fifo_empty),
        .head_entry  (head_entry),
        .head_addr   (head_addr),
        .pop         (pop),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .total_score (total_score)
    );

endmodule
